// ===== rtl/kmce_pkg.sv =====
// Package for the k-means cluster engine: sizes, op codes, state types.
// No dependencies.
package kmce_pkg;
   localparam int MaxPoints   = 1024;
   localparam int MaxDims     = 8;
   localparam int MaxClusters = 16;
   localparam int PtIdxW      = $clog2(MaxPoints);
   localparam int ClIdxW      = $clog2(MaxClusters);
   localparam int CntW        = PtIdxW + 1;
   localparam int SumW        = 16 + CntW;
   localparam int DistW       = 2 * 17 + 3;
   localparam int DimW        = $clog2(MaxDims);

   typedef logic signed [15:0] coord_type;
   typedef coord_type [MaxDims-1:0] vec_type;

   typedef enum logic [1:0] {
      OP_LOAD_POINT = 2'd0,
      OP_LOAD_CENT  = 2'd1,
      OP_RUN        = 2'd2,
      OP_QUERY      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_DIMS  = 2'd0,
      CSR_NPTS  = 2'd1,
      CSR_NCLS  = 2'd2,
      CSR_ITERS = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_FETCH, ST_SCAN, ST_ACCUM, ST_DIV,
      ST_EMIT, ST_QRD, ST_QOUT
   } state_type;
endpackage

// ===== rtl/kmce_div.sv =====
// Restoring divider: signed sum over unsigned count, truncated toward zero.
// Uses kmce_pkg.
module kmce_div import kmce_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [SumW-1:0] dividend,
   input  logic [CntW-1:0]        divisor,
   output logic                   done,
   output coord_type              quotient
);
   logic [SumW-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [CntW-1:0]  den_ff, den_in;
   logic             neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [$clog2(SumW+1)-1:0] cnt_ff, cnt_in;
   logic [SumW:0]    trial;
   logic [SumW-1:0]  qfix;

   // one quotient bit per cycle
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[SumW-1]} - {{(SumW+1-CntW){1'b0}}, den_ff};
      if (start) begin
         neg_in  = dividend[SumW-1];
         quo_in  = dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[SumW]) rem_in = trial[SumW-1:0];
         else rem_in = {rem_ff[SumW-2:0], quo_ff[SumW-1]};
         quo_in = {quo_ff[SumW-2:0], ~trial[SumW]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(SumW+1))'(SumW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
   end

   assign qfix     = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient = qfix[15:0];
   assign done     = done_ff;
endmodule

// ===== rtl/kmce_lane.sv =====
// One distance lane: squared difference of one coordinate, registered.
// Uses kmce_pkg.
module kmce_lane import kmce_pkg::*; (
   input  logic      clock,
   input  logic      enable,
   input  coord_type pt,
   input  coord_type cen,
   output logic [33:0] sq
);
   logic signed [16:0] diff;
   logic [33:0] sq_ff;

   assign diff = 17'(pt) - 17'(cen);

   // register the square
   always_ff @(posedge clock) begin
      sq_ff <= enable ? 34'(diff * diff) : '0;
   end
   assign sq = sq_ff;
endmodule

// ===== rtl/kmce_merge.sv =====
// Merge stage: adds the lane squares and keeps the running minimum.
// Uses kmce_pkg.
module kmce_merge import kmce_pkg::*; (
   input  logic                         clock,
   input  logic                         first,
   input  logic                         valid,
   input  logic [ClIdxW-1:0]            cand,
   input  logic [MaxDims-1:0][33:0]     sq,
   output logic [ClIdxW-1:0]            best
);
   logic [DistW-1:0]  sum;
   logic [DistW-1:0]  bestd_ff;
   logic [ClIdxW-1:0] best_ff;

   always_comb begin
      sum = '0;
      for (int d = 0; d < MaxDims; d++) sum = sum + DistW'(sq[d]);
   end

   // strict less keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (valid && (first || sum < bestd_ff)) begin
         bestd_ff <= sum;
         best_ff  <= cand;
      end
   end
   assign best = best_ff;
endmodule

// ===== rtl/kmeans_cluster_engine_top.sv =====
// Top level of the k-means cluster engine.
// Uses kmce_pkg, kmce_lane, kmce_merge and kmce_div.
//
// Usage: req_ carries one op per beat. Loads (ops 0,1) write a point or a
// centroid, give no result and leave the engine idle for the next beat. A
// query (op 3) steps through ST_QRD and ST_QOUT and then raises rsp_valid
// with one beat, kind 1 and last 1. A run (op 2) does iteration_count Lloyd
// passes and then sends K centroid beats, last set on the final one.
// Each pass clears the sums of every cluster slot, assigns each point (eight
// lanes compute one centroid distance per cycle and a merge stage tracks the
// minimum), then computes each centroid coordinate in the serial divider,
// an empty cluster skipping the divider. One item is in work at a time;
// req_stall is high while busy. csr_ writes are taken only while idle.
// Reset clears the control state and a fill count of the points that any
// pass has covered, so every assignment reads as zero until a run covers
// it. When rsp_stall is high the result register holds its beat and the
// engine waits before it sends its next beat.
module kmeans_cluster_engine_top import kmce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_item_index,
   input  logic signed [15:0] req_coord_0, req_coord_1, req_coord_2, req_coord_3,
   input  logic signed [15:0] req_coord_4, req_coord_5, req_coord_6, req_coord_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [9:0]  rsp_result_index,
   output logic [3:0]  rsp_cluster_id,
   output logic signed [15:0] rsp_out_coord_0, rsp_out_coord_1, rsp_out_coord_2,
   output logic signed [15:0] rsp_out_coord_3, rsp_out_coord_4, rsp_out_coord_5,
   output logic signed [15:0] rsp_out_coord_6, rsp_out_coord_7,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   // registers
   logic [3:0]  dims_ff;
   logic [10:0] npts_ff;
   logic [4:0]  ncls_ff;
   logic [7:0]  iters_ff;
   state_type   st_ff, st_in;
   logic [PtIdxW:0]   pi_ff, pi_in;
   logic [ClIdxW:0]   ci_ff, ci_in;
   logic [7:0]        it_ff, it_in;
   logic [DimW:0]     di_ff, di_in;
   logic [2:0]        ph_ff, ph_in;
   logic [PtIdxW-1:0] qidx_ff;
   logic              qoor_ff;

   // memories
   vec_type                 pmem [MaxPoints];
   vec_type                 cmem [MaxClusters];
   logic [ClIdxW-1:0]       amem [MaxPoints];
   logic [PtIdxW:0]         cover_ff;
   logic signed [SumW-1:0]  smem [MaxClusters][MaxDims];
   logic [CntW-1:0]         cnt_ff [MaxClusters];

   vec_type           prd_ff, crd_ff;
   logic [ClIdxW-1:0] ard_ff;
   logic              ardv_ff;

   // response register
   logic              rv_ff, rk_ff, rl_ff;
   logic [9:0]        ri_ff;
   logic [3:0]        rc_ff;
   vec_type           ro_ff;

   logic [3:0] nd;
   logic [10:0] np;
   logic [4:0] nk;
   logic req_acc, rsp_free;
   vec_type req_vec, mask_vec, cmask;
   logic [MaxDims-1:0][33:0] sq;
   logic [ClIdxW-1:0] best;
   logic lane_en, merge_v, merge_first;
   logic [ClIdxW-1:0] merge_cand;
   logic div_start, div_done;
   coord_type div_q;
   logic [ClIdxW-1:0] ci_s;
   logic [DimW-1:0] di_s;

   assign nd = (dims_ff == 0) ? 4'd1 : (dims_ff > 4'(MaxDims)) ? 4'(MaxDims) : dims_ff;
   assign np = (npts_ff == 0) ? 11'd1 : (npts_ff > 11'(MaxPoints)) ? 11'(MaxPoints) : npts_ff;
   assign nk = (ncls_ff == 0) ? 5'd1 : (ncls_ff > 5'(MaxClusters)) ? 5'(MaxClusters) : ncls_ff;
   assign ci_s = ci_ff[ClIdxW-1:0];
   assign di_s = di_ff[DimW-1:0];

   assign req_vec = {req_coord_7, req_coord_6, req_coord_5, req_coord_4,
                     req_coord_3, req_coord_2, req_coord_1, req_coord_0};
   assign req_stall = (st_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = (st_ff == ST_IDLE);
   assign rsp_free  = !rv_ff || !rsp_stall;

   always_comb begin
      for (int d = 0; d < MaxDims; d++) mask_vec[d] = (d < nd) ? 16'hFFFF : 16'h0;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 4'd2; npts_ff <= 11'd1024; ncls_ff <= 5'd4; iters_ff <= 8'd150;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIMS:  dims_ff  <= csr_data[3:0];
            CSR_NPTS:  npts_ff  <= csr_data;
            CSR_NCLS:  ncls_ff  <= csr_data[4:0];
            CSR_ITERS: iters_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // next state: ph steps the phases of the divide loop
   always_comb begin
      st_in = st_ff; pi_in = pi_ff; ci_in = ci_ff; it_in = it_ff;
      di_in = di_ff; ph_in = ph_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (op_type'(req_op))
                  OP_RUN: begin
                     it_in = '0; ci_in = '0; di_in = '0;
                     st_in = (iters_ff == 0) ? ST_EMIT : ST_CLEAR;
                  end
                  OP_QUERY: st_in = ST_QRD;
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            ci_in = ci_ff + 1'b1;
            if (ci_ff == (ClIdxW+1)'(MaxClusters - 1)) begin
               pi_in = '0; st_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ci_in = '0; st_in = ST_SCAN;
         end
         ST_SCAN: begin
            // crd read at ci, lane at ci-1, merge at ci-2
            ci_in = ci_ff + 1'b1;
            if (ci_ff == (ClIdxW+1)'(nk) + 1'b1) st_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            pi_in = pi_ff + 1'b1;
            if (pi_ff + 1'b1 == (PtIdxW+1)'(np)) begin
               ci_in = '0; di_in = '0; ph_in = '0; st_in = ST_DIV;
            end else st_in = ST_FETCH;
         end
         ST_DIV: begin
            if (ph_ff == 3'd0) ph_in = 3'd1;
            else if (ph_ff == 3'd1) begin
               if (cnt_ff[ci_s] == 0 || di_ff >= (DimW+1)'(nd)) ph_in = 3'd3;
               else ph_in = 3'd2;
            end else if (ph_ff == 3'd2) begin
               if (div_done) begin di_in = di_ff + 1'b1; ph_in = 3'd1; end
            end else begin
               di_in = '0; ph_in = '0; ci_in = ci_ff + 1'b1;
               if (ci_ff + 1'b1 == (ClIdxW+1)'(nk)) begin
                  it_in = it_ff + 1'b1; ci_in = '0;
                  st_in = (it_ff + 1'b1 == iters_ff) ? ST_EMIT : ST_CLEAR;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               ci_in = ci_ff + 1'b1;
               if (ci_ff + 1'b1 == (ClIdxW+1)'(nk)) st_in = ST_IDLE;
            end
         end
         ST_QRD: st_in = ST_QOUT;
         ST_QOUT: if (rsp_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      lane_en = 1'b0; merge_v = 1'b0; merge_first = 1'b0; merge_cand = '0;
      div_start = 1'b0;
      case (st_ff)
         ST_SCAN: begin
            lane_en = (ci_ff >= 1) && (ci_ff <= (ClIdxW+1)'(nk));
            merge_v = (ci_ff >= 2);
            merge_first = (ci_ff == 2);
            merge_cand = ClIdxW'(ci_ff - 2'd2);
         end
         ST_DIV: div_start = (ph_ff == 3'd1) && cnt_ff[ci_s] != 0 &&
                             di_ff < (DimW+1)'(nd);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      pi_ff <= pi_in; ci_ff <= ci_in; it_ff <= it_in; di_ff <= di_in; ph_ff <= ph_in;
   end

   // point and centroid stores; a query's point is read at its accepting edge
   always_ff @(posedge clock) begin
      if (req_acc && op_type'(req_op) == OP_LOAD_POINT)
         pmem[req_item_index[PtIdxW-1:0]] <= req_vec;
      if (st_ff == ST_FETCH || st_ff == ST_IDLE)
         prd_ff <= pmem[(st_ff == ST_IDLE) ? req_item_index[PtIdxW-1:0]
                                             : pi_ff[PtIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_acc && op_type'(req_op) == OP_LOAD_CENT && req_item_index < 10'(MaxClusters))
         cmem[req_item_index[ClIdxW-1:0]] <= req_vec;
      else if (st_ff == ST_DIV && ph_ff == 3'd2 && div_done)
         cmem[ci_s][di_s] <= div_q;
      crd_ff <= cmem[ci_s];
   end

   // assignment store; passes always cover a prefix, so a fill count marks
   // the entries that hold an assignment
   always_ff @(posedge clock) begin
      if (reset) cover_ff <= '0;
      else if (st_ff == ST_ACCUM && pi_ff >= cover_ff) cover_ff <= pi_ff + 1'b1;
      if (st_ff == ST_ACCUM) amem[pi_ff[PtIdxW-1:0]] <= best;
      ard_ff  <= amem[qidx_ff];
      ardv_ff <= ({1'b0, qidx_ff} < cover_ff);
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         qidx_ff <= req_item_index[PtIdxW-1:0];
         qoor_ff <= 1'b0;
      end
   end

   // sums and counts
   always_ff @(posedge clock) begin
      if (st_ff == ST_CLEAR) begin
         cnt_ff[ci_s] <= '0;
         for (int d = 0; d < MaxDims; d++) smem[ci_s][d] <= '0;
      end else if (st_ff == ST_ACCUM) begin
         cnt_ff[best] <= cnt_ff[best] + 1'b1;
         for (int d = 0; d < MaxDims; d++)
            if (d < nd) smem[best][d] <= smem[best][d] + SumW'(prd_ff[d]);
      end
   end

   // lanes and merge
   for (genvar g = 0; g < MaxDims; g++) begin : g_lane
      kmce_lane u_lane (
         .clock  (clock),
         .enable (lane_en && (g < nd)),
         .pt     (prd_ff[g]),
         .cen    (crd_ff[g]),
         .sq     (sq[g])
      );
   end

   kmce_merge u_merge (
      .clock (clock),
      .first (merge_first),
      .valid (merge_v),
      .cand  (merge_cand),
      .sq    (sq),
      .best  (best)
   );

   kmce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (smem[ci_s][di_s]),
      .divisor  (cnt_ff[ci_s]),
      .done     (div_done),
      .quotient (div_q)
   );

   // result register
   always_comb begin
      for (int d = 0; d < MaxDims; d++) cmask[d] = cmem[ci_s][d] & mask_vec[d];
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (rsp_free) rv_ff <= (st_ff == ST_EMIT) || (st_ff == ST_QOUT);
      if (rsp_free) begin
         if (st_ff == ST_EMIT) begin
            rk_ff <= 1'b0;
            ri_ff <= 10'(ci_s);
            rc_ff <= 4'(ci_s);
            ro_ff <= cmask;
            rl_ff <= (ci_ff + 1'b1 == (ClIdxW+1)'(nk));
         end else if (st_ff == ST_QOUT) begin
            rk_ff <= 1'b1;
            ri_ff <= 10'(qidx_ff);
            rc_ff <= (ardv_ff && !qoor_ff) ? 4'(ard_ff) : 4'd0;
            for (int d = 0; d < MaxDims; d++) ro_ff[d] <= prd_ff[d] & mask_vec[d];
            rl_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_kind = rk_ff;
   assign rsp_result_index = ri_ff;
   assign rsp_cluster_id = rc_ff;
   assign rsp_last = rl_ff;
   assign {rsp_out_coord_7, rsp_out_coord_6, rsp_out_coord_5, rsp_out_coord_4,
           rsp_out_coord_3, rsp_out_coord_2, rsp_out_coord_1, rsp_out_coord_0} = ro_ff;
endmodule

// ===== rtl/kmce_checker.sv =====
// Port checker for the k-means cluster engine, bound to the top level.
// Uses kmce_pkg.
module kmce_checker import kmce_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic       rsp_last,
   input logic [9:0] rsp_result_index,
   input logic [3:0] rsp_cluster_id
);
   // a query answer is always a single beat
   a_query_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last) else $error("query beat without last");

   // centroid beats carry their own index as cluster id
   a_cent_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_result_index == 10'(rsp_cluster_id))
      else $error("centroid index mismatch");

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_index))
      else $error("stalled beat changed");
endmodule

bind kmeans_cluster_engine_top kmce_checker u_kmce_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
   .rsp_last(rsp_last), .rsp_result_index(rsp_result_index),
   .rsp_cluster_id(rsp_cluster_id)
);
